// ===== sv/aeske_pkg.sv =====
// shared types, s-box and round constants for the aes-128 key expansion
package aeske_pkg;

  localparam int unsigned ROUND_LAST = 10;
  localparam int unsigned RND_W      = 4;

  typedef struct packed {
    logic [63:0] key_upper;
    logic [63:0] key_lower;
  } aeske_in_t;

  typedef struct packed {
    logic [3:0]  round_number;
    logic [63:0] round_key_upper;
    logic [63:0] round_key_lower;
    logic        final_round;
  } aeske_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
    8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
    8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
    8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
    8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  // rcon for the round key being produced, 1..10
  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1B;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/aes128_key_expansion.sv =====
// aes-128 key expansion top level: one cipher key in, eleven round keys out
//
//  channel  ports                     handshake
//  input    start, busy, in_word      word taken when start high and busy low
//  result   out_strobe, out_word      one word per cycle while out_strobe high
//
// a key yields round keys 0..10 on consecutive cycles, the first in the
// cycle after the key is taken; one s-box word step per cycle sets the pace.
// busy is low when idle and on the cycle showing round key 10, so keys can
// follow each other back to back with no gap on the result side.
// synchronous active-low reset clears the run flag; nothing is emitted until a key is taken.
// the receiver cannot stall: each result word is shown for one cycle only.
module aes128_key_expansion (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  aeske_pkg::aeske_in_t   in_word,
  output logic                   out_strobe,
  output aeske_pkg::aeske_out_t  out_word
);
  import aeske_pkg::*;

  logic           active_r, active_nxt;
  logic [3:0]     round_r, round_nxt;
  logic [127:0]   key_r, key_nxt;
  logic [127:0]   key_step;
  logic           last;
  logic           take;

  aeske_round u_round (
    .key_prev (key_r),
    .rnd_next (round_r + 4'd1),
    .key_next (key_step)
  );

  assign last = (round_r == RND_W'(ROUND_LAST));
  assign busy = active_r && !last;
  assign take = start && !busy;

  always_comb begin
    active_nxt = active_r;
    round_nxt  = round_r;
    key_nxt    = key_r;
    if (take) begin
      active_nxt = 1'b1;
      round_nxt  = 4'd0;
      key_nxt    = {in_word.key_upper, in_word.key_lower};
    end else if (active_r) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        round_nxt = round_r + 4'd1;
        key_nxt   = key_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      round_r  <= 4'd0;
    end else begin
      active_r <= active_nxt;
      round_r  <= round_nxt;
    end
    key_r <= key_nxt;
  end

  assign out_strobe               = active_r;
  assign out_word.round_number    = round_r;
  assign out_word.round_key_upper = key_r[127:64];
  assign out_word.round_key_lower = key_r[63:0];
  assign out_word.final_round     = last;

endmodule

// ===== sv/aeske_round.sv =====
// one step of the key schedule: previous round key in, next round key out
module aeske_round (
  input  logic [127:0] key_prev,
  input  logic [3:0]   rnd_next,
  output logic [127:0] key_next
);
  import aeske_pkg::*;

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] rot, sub, t;
  logic [31:0] n0, n1, n2, n3;

  always_comb begin
    w0  = key_prev[127:96];
    w1  = key_prev[95:64];
    w2  = key_prev[63:32];
    w3  = key_prev[31:0];
    rot = {w3[23:0], w3[31:24]};
    sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
    t   = sub ^ {rcon(rnd_next), 24'h000000};
    n0  = w0 ^ t;
    n1  = w1 ^ n0;
    n2  = w2 ^ n1;
    n3  = w3 ^ n2;
    key_next = {n0, n1, n2, n3};
  end

endmodule

// ===== sv/aeske_checker.sv =====
// port-level checks for the key expansion, bound to the top level
module aeske_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input aeske_pkg::aeske_in_t   in_word,
  input logic                   out_strobe,
  input aeske_pkg::aeske_out_t  out_word
);
  import aeske_pkg::*;

  // key taken: round key 0 is the key itself on the next cycle
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_strobe && out_word.round_number == 4'd0
      && out_word.round_key_upper == $past(in_word.key_upper)
      && out_word.round_key_lower == $past(in_word.key_lower))
    else $error("round key 0 does not follow accepted key");

  // rounds count up without gaps
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_word.final_round |=> out_strobe
      && out_word.round_number == 4'($past(out_word.round_number) + 4'd1))
    else $error("round sequence broken");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_word.final_round == (out_word.round_number == 4'd10))
    else $error("final flag does not match round 10");

  // busy only while a run has words left
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_strobe && !out_word.final_round)
    else $error("busy without a run in progress");

endmodule

bind aes128_key_expansion aeske_checker u_aeske_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_word    (in_word),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

// ===== tb/tb.sv =====
// self-checking testbench for the aes-128 key expansion: known vector, edge keys, back-to-back and random keys
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aeske_pkg::*;

  localparam int unsigned RANDOM_KEYS  = 160;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam logic [7:0] GF_POLY    = 8'h1B;
  localparam logic [7:0] AFFINE_C   = 8'h63;
  localparam logic [7:0] RCON_FIRST = 8'h01;

  localparam logic [127:0] FIPS_KEY  = 128'h2b7e151628aed2a6abf7158809cf4f3c;
  localparam logic [127:0] FIPS_LAST = 128'hd014f9a8c9ee2589e13f0cc8b6630ca6;

  localparam logic [127:0] EDGE_KEYS [10] = '{
    128'h0000_0000_0000_0000_0000_0000_0000_0000,
    128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,
    128'h5555_5555_5555_5555_5555_5555_5555_5555,
    128'haaaa_aaaa_aaaa_aaaa_aaaa_aaaa_aaaa_aaaa,
    128'hffff_ffff_ffff_ffff_0000_0000_0000_0000,
    128'h0000_0000_0000_0000_ffff_ffff_ffff_ffff,
    128'h8000_0000_0000_0000_0000_0000_0000_0000,
    128'h0000_0000_0000_0000_0000_0000_0000_0001,
    128'h0001_0203_0405_0607_0809_0a0b_0c0d_0e0f,
    128'h0000_0000_0000_0000_0000_0000_5252_5252
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  aeske_in_t  in_word = '0;
  logic       out_strobe;
  aeske_out_t out_word;

  aeske_out_t  round_keys_due [$];
  int unsigned mismatches = 0;

  aes128_key_expansion i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= x;
      x = xtime(x);
    end
    return p;
  endfunction

  // field inverse as x^254, then the affine map
  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] sq;
    inv = 8'h01;
    sq  = x;
    for (int i = 1; i < 8; i++) begin
      sq  = gf_mul(sq, sq);
      inv = gf_mul(inv, sq);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

  function automatic void expand_key(input aeske_in_t k);
    logic [31:0] w [4];
    logic [31:0] t;
    logic [7:0]  rc;
    aeske_out_t  rk;
    w[0] = k.key_upper[63:32];
    w[1] = k.key_upper[31:0];
    w[2] = k.key_lower[63:32];
    w[3] = k.key_lower[31:0];
    rc   = RCON_FIRST;
    for (int r = 0; r <= ROUND_LAST; r++) begin
      if (r > 0) begin
        t    = sub_word({w[3][23:0], w[3][31:24]}) ^ {rc, 24'h0};
        rc   = xtime(rc);
        w[0] ^= t;
        w[1] ^= w[0];
        w[2] ^= w[1];
        w[3] ^= w[2];
      end
      rk.round_number    = RND_W'(r);
      rk.round_key_upper = {w[0], w[1]};
      rk.round_key_lower = {w[2], w[3]};
      rk.final_round     = (r == ROUND_LAST);
      round_keys_due.push_back(rk);
    end
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // start stays high from one word to the next when the gap is zero
  task automatic send_key(input aeske_in_t k, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_word <= {$urandom, $urandom, $urandom, $urandom};
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    expand_key(k);
  endtask

  always @(posedge clk) begin
    aeske_out_t exp_rk;
    if (out_strobe === 1'b1) begin
      if (round_keys_due.size() == 0) begin
        $display("%0t unexpected round key: expected none, actual %h", $time, out_word);
        mismatches++;
      end else begin
        exp_rk = round_keys_due.pop_front();
        if (out_word.round_number !== exp_rk.round_number) begin
          $display("%0t round_number: expected %0d, actual %0d", $time,
                   exp_rk.round_number, out_word.round_number);
          mismatches++;
        end
        if (out_word.round_key_upper !== exp_rk.round_key_upper) begin
          $display("%0t round_key_upper (round %0d): expected %h, actual %h", $time,
                   exp_rk.round_number, exp_rk.round_key_upper, out_word.round_key_upper);
          mismatches++;
        end
        if (out_word.round_key_lower !== exp_rk.round_key_lower) begin
          $display("%0t round_key_lower (round %0d): expected %h, actual %h", $time,
                   exp_rk.round_number, exp_rk.round_key_lower, out_word.round_key_lower);
          mismatches++;
        end
        if (out_word.final_round !== exp_rk.final_round) begin
          $display("%0t final_round (round %0d): expected %b, actual %b", $time,
                   exp_rk.round_number, exp_rk.final_round, out_word.final_round);
          mismatches++;
        end
      end
    end
  end

  task automatic test_fips_vector();
    aeske_out_t last_rk;
    send_key(FIPS_KEY, 2);
    last_rk = round_keys_due[$];
    if ({last_rk.round_key_upper, last_rk.round_key_lower} !== FIPS_LAST) begin
      $display("%0t predicted last round key: expected %h, actual %h", $time, FIPS_LAST,
               {last_rk.round_key_upper, last_rk.round_key_lower});
      mismatches++;
    end
  endtask

  task automatic test_edge_keys();
    foreach (EDGE_KEYS[i]) send_key(EDGE_KEYS[i], $urandom_range(0, 4));
  endtask

  task automatic test_back_to_back();
    for (int n = 0; n < 6; n++) begin
      send_key({$urandom, $urandom, $urandom, $urandom}, 0);
    end
    send_key(FIPS_KEY, 40);
  endtask

  task automatic test_random_keys();
    int unsigned burst;
    burst = 0;
    for (int n = 0; n < RANDOM_KEYS; n++) begin
      if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(4, 12);
      if (burst > 0) begin
        burst--;
        send_key({$urandom, $urandom, $urandom, $urandom}, 0);
      end else begin
        send_key({$urandom, $urandom, $urandom, $urandom}, rand_gap());
      end
    end
  endtask

  initial begin
    for (int unsigned c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("aes128_key_expansion regression: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_fips_vector();
    test_edge_keys();
    test_back_to_back();
    test_random_keys();
    @(negedge clk);
    start <= 1'b0;
    while (round_keys_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("aes128_key_expansion regression: pass");
    end else begin
      $display("aes128_key_expansion regression: fail");
    end
    $finish;
  end

endmodule
